/* design/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants for the sensor packet deframer
// Phase encoding, report codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] CFG_START_CODE = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS = 2'd2;

	localparam logic [15:0] START_CODE_RST = 16'hEF01;
	localparam logic [31:0] DEVICE_ADDRESS_RST = 32'hFFFF_FFFF;
	localparam logic [19:0] TIMEOUT_TICKS_RST = 20'd1000;

	// length field counts payload plus the two checksum bytes
	localparam logic [15:0] CHK_BYTES = 16'd2;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_BAD_START = 3'd1,
		ST_ADDR_MISMATCH = 3'd2,
		ST_SHORT_LEN = 3'd3,
		ST_CHECKSUM = 3'd4,
		ST_TIMEOUT = 3'd5
	} status_t;

	typedef enum logic [8:0] {
		PH_HUNT = 9'b000000001,
		PH_START_LO = 9'b000000010,
		PH_ADDR = 9'b000000100,
		PH_TYPE = 9'b000001000,
		PH_LEN_HI = 9'b000010000,
		PH_LEN_LO = 9'b000100000,
		PH_PAYLOAD = 9'b001000000,
		PH_CHK_HI = 9'b010000000,
		PH_CHK_LO = 9'b100000000
	} phase_t;

endpackage

/* design/sensor_packet_deframer_core.sv */
// ----------------------------------------------------------------------------
// sensor_packet_deframer_core: serial packet deframer with 16-bit sum check
// Hunts start code, checks address, forwards payload bytes, reports each end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, op, rx_byte) carries one received byte
//   (op = 0) or one time tick (op = 1) per transfer. Output channel
//   (out_valid/out_stall) carries at most one result per input item: a
//   payload byte (kind = 0) or an end-of-packet report (kind = 1).
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//   only while no item is in flight.
// Throughput:
//   An accepted item lands in the input register, and its result goes on to
//   the output register, which raises out_valid.
//   One item per cycle sustained while out_stall is low; the per-byte state
//   update is a single pass of short logic between the two registers.
// Reset:
//   arst_n clears the valid bits of both registers and the deframer state
//   (hunting), and loads the register reset values.
// Stall:
//   While out_stall holds a result, the input register holds its item and
//   in_stall rises once that register is full; no item is dropped.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_core
	import spd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                kind,
	output logic [7:0]          packet_type,
	output logic [7:0]          data_byte,
	output logic [15:0]         payload_length,
	output logic [2:0]          status
);

	// configuration
	logic [15:0] start_code_q;
	logic [31:0] device_address_q;
	logic [19:0] timeout_ticks_q;

	// input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	// deframer state
	phase_t      phase_q, phase_n;
	logic [15:0] position_q, position_n;
	logic [15:0] decl_len_q, decl_len_n;
	logic [15:0] sum_q, sum_n;
	logic [7:0]  chk_hi_q, chk_hi_n;
	logic [7:0]  type_q, type_n;
	logic        addr_bad_q, addr_bad_n;
	logic [19:0] idle_q, idle_n;

	// result
	logic        emit;
	logic        kind_n;
	logic [7:0]  data_n;
	logic [15:0] plen_n;
	status_t     status_n;

	logic        out_valid_q;
	logic        advance;
	logic        load_s1;

	logic [7:0]  addr_sel;
	logic [15:0] pos_inc;
	logic [19:0] idle_inc;
	logic [15:0] len_full;
	logic [15:0] pay_len;
	logic        addr_miss;

	assign advance = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign load_s1 = in_valid && !in_stall;

	assign pos_inc = position_q + 16'd1;
	assign idle_inc = idle_q + 20'd1;
	assign len_full = {decl_len_q[15:8], byte_s1};
	assign pay_len = decl_len_q - CHK_BYTES;

	always_comb begin
		unique case (position_q[1:0])
			2'd0: addr_sel = device_address_q[31:24];
			2'd1: addr_sel = device_address_q[23:16];
			2'd2: addr_sel = device_address_q[15:8];
			default: addr_sel = device_address_q[7:0];
		endcase
	end
	assign addr_miss = addr_bad_q || (addr_sel != byte_s1);

	always_comb begin
		phase_n = phase_q;
		position_n = position_q;
		decl_len_n = decl_len_q;
		sum_n = sum_q;
		chk_hi_n = chk_hi_q;
		type_n = type_q;
		addr_bad_n = addr_bad_q;
		idle_n = idle_q;
		emit = 1'b0;
		kind_n = KIND_REPORT;
		data_n = 8'd0;
		plen_n = 16'd0;
		status_n = ST_OK;

		if (op_s1 == OP_TICK) begin
			if (phase_q != PH_HUNT) begin
				idle_n = idle_inc;
				// a wrap to zero also times out (zero limit acts as one)
				if (idle_inc >= timeout_ticks_q || idle_inc == 20'd0) begin
					emit = 1'b1;
					status_n = ST_TIMEOUT;
					phase_n = PH_HUNT;
					idle_n = 20'd0;
				end
			end
		end else begin
			idle_n = 20'd0;
			unique case (phase_q)
				PH_HUNT: begin
					// sum register parks the first start byte
					sum_n = {8'd0, byte_s1};
					type_n = 8'd0;
					decl_len_n = 16'd0;
					phase_n = PH_START_LO;
				end
				PH_START_LO: begin
					if ({sum_q[7:0], byte_s1} != start_code_q) begin
						emit = 1'b1;
						status_n = ST_BAD_START;
						phase_n = PH_HUNT;
					end else begin
						position_n = 16'd0;
						addr_bad_n = 1'b0;
						phase_n = PH_ADDR;
					end
				end
				PH_ADDR: begin
					addr_bad_n = addr_miss;
					position_n = pos_inc;
					if (pos_inc[2]) begin
						if (addr_miss) begin
							emit = 1'b1;
							status_n = ST_ADDR_MISMATCH;
							phase_n = PH_HUNT;
						end else begin
							phase_n = PH_TYPE;
						end
					end
				end
				PH_TYPE: begin
					type_n = byte_s1;
					sum_n = {8'd0, byte_s1};
					phase_n = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					decl_len_n = {byte_s1, 8'd0};
					sum_n = sum_q + {8'd0, byte_s1};
					phase_n = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					decl_len_n = len_full;
					sum_n = sum_q + {8'd0, byte_s1};
					if (len_full < CHK_BYTES) begin
						emit = 1'b1;
						status_n = ST_SHORT_LEN;
						phase_n = PH_HUNT;
					end else begin
						position_n = 16'd0;
						phase_n = (len_full == CHK_BYTES) ? PH_CHK_HI : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					sum_n = sum_q + {8'd0, byte_s1};
					position_n = pos_inc;
					if (pos_inc >= pay_len) phase_n = PH_CHK_HI;
					emit = 1'b1;
					kind_n = KIND_DATA;
					data_n = byte_s1;
				end
				PH_CHK_HI: begin
					chk_hi_n = byte_s1;
					phase_n = PH_CHK_LO;
				end
				PH_CHK_LO: begin
					emit = 1'b1;
					plen_n = pay_len;
					status_n = ({chk_hi_q, byte_s1} == sum_q) ? ST_OK : ST_CHECKSUM;
					phase_n = PH_HUNT;
				end
				default: begin
					phase_n = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= START_CODE_RST;
			device_address_q <= DEVICE_ADDRESS_RST;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_CODE: start_code_q <= cfg_data[15:0];
				CFG_DEVICE_ADDRESS: device_address_q <= cfg_data;
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			op_s1 <= op;
			byte_s1 <= rx_byte;
		end
	end

	// state update and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			position_q <= 16'd0;
			decl_len_q <= 16'd0;
			sum_q <= 16'd0;
			chk_hi_q <= 8'd0;
			type_q <= 8'd0;
			addr_bad_q <= 1'b0;
			idle_q <= 20'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
			if (valid_s1) begin
				phase_q <= phase_n;
				position_q <= position_n;
				decl_len_q <= decl_len_n;
				sum_q <= sum_n;
				chk_hi_q <= chk_hi_n;
				type_q <= type_n;
				addr_bad_q <= addr_bad_n;
				idle_q <= idle_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			kind <= kind_n;
			packet_type <= type_q;
			data_byte <= data_n;
			payload_length <= plen_n;
			status <= status_n;
		end
	end

	assign out_valid = out_valid_q;

	// payload results carry no status and no length
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind == KIND_DATA) |-> (status == ST_OK) && (payload_length == 16'd0))
		else $error("payload result with status or length set");

	// only ok and checksum reports carry a length
	a_len_in_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind == KIND_REPORT) && (payload_length != 16'd0)
		|-> (status == ST_OK) || (status == ST_CHECKSUM))
		else $error("length in a header or timeout report");

	// every report returns the deframer to hunting
	a_report_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && emit && (kind_n == KIND_REPORT)
		|=> (phase_q == PH_HUNT) && (idle_q == 20'd0))
		else $error("report without return to hunting");

	// input only held back when the input register is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with free input register");

endmodule
